@@ rtl/sorted_interval_lookup_defines.svh @@
// Assertion macros used by the checker.
`ifndef SORTED_INTERVAL_LOOKUP_DEFINES_SVH
`define SORTED_INTERVAL_LOOKUP_DEFINES_SVH

// same-cycle implication
`define SIL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sil check failed");

// next-cycle implication
`define SIL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sil check failed");

`endif

@@ rtl/sil_pkg.sv @@
`default_nettype none
package sil_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 1024;

   localparam int KIND_W         = 1;
   localparam int ENTRY_INDEX_W  = 10;
   localparam int ADDRESS_W      = 32;
   localparam int COUNT_W        = 11;
   localparam int REGION_INDEX_W = 10;

   localparam logic [KIND_W-1:0] KIND_QUERY = 1'b0;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b1;

   typedef struct packed {
      logic load;
      logic query;
      logic step;
      logic finish;
   } sil_cmd_type;

   typedef struct packed {
      logic lo_lt_hi;
   } sil_status_type;

endpackage
`default_nettype wire

@@ rtl/sorted_interval_lookup.sv @@
// Load word: accepted when start is high and busy low, written that cycle, no result.
// Query word: result strobe rsp_valid ends the search over the clamped entry count,
// one table probe per cycle. busy drops with the result, so the next word is taken in
// the cycle the result shows: a query holds off the input until then, while a load
// never raises busy and holds the input only in its accept cycle.
// Receiver cannot stall; synchronous reset clears control and entry count, not the table.
`default_nettype none
module sorted_interval_lookup #(
   parameter int MAX_ENTRIES = sil_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [sil_pkg::KIND_W-1:0]           req_kind,
   input  wire logic [sil_pkg::ENTRY_INDEX_W-1:0]    req_entry_index,
   input  wire logic [sil_pkg::ADDRESS_W-1:0]        req_address,
   output logic                                      rsp_valid,
   output logic                                      rsp_found,
   output logic [sil_pkg::REGION_INDEX_W-1:0]        rsp_region_index,
   input  wire logic                                 csr_write_enable,
   input  wire logic [sil_pkg::COUNT_W-1:0]          csr_entry_count
);
   import sil_pkg::*;

   sil_cmd_type    cmd;
   sil_status_type status;

   sil_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   sil_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_entry_count  (csr_entry_count),
      .req_entry_index  (req_entry_index),
      .req_address      (req_address),
      .rsp_found        (rsp_found),
      .rsp_region_index (rsp_region_index)
   );

endmodule
`default_nettype wire

@@ rtl/sil_ctrl.sv @@
`default_nettype none
module sil_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [sil_pkg::KIND_W-1:0]     req_kind,
   input  wire sil_pkg::sil_status_type        status,
   output sil_pkg::sil_cmd_type                cmd,
   output logic                                busy,
   output logic                                rsp_valid
);
   import sil_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff;
   logic accept;

   assign busy   = (state_ff == ST_SEARCH);
   assign accept = start && !busy;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.query = 1'b1;
                  state_in  = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (status.lo_lt_hi) begin
               cmd.step = 1'b1;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ rtl/sil_dp.sv @@
`default_nettype none
module sil_dp #(
   parameter int MAX_ENTRIES = sil_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire sil_pkg::sil_cmd_type                 cmd,
   output sil_pkg::sil_status_type                   status,
   input  wire logic                                 csr_write_enable,
   input  wire logic [sil_pkg::COUNT_W-1:0]          csr_entry_count,
   input  wire logic [sil_pkg::ENTRY_INDEX_W-1:0]    req_entry_index,
   input  wire logic [sil_pkg::ADDRESS_W-1:0]        req_address,
   output logic                                      rsp_found,
   output logic [sil_pkg::REGION_INDEX_W-1:0]        rsp_region_index
);
   import sil_pkg::*;

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   logic [ADDRESS_W-1:0] mem [MAX_ENTRIES];

   logic [COUNT_W-1:0]        count_ff;
   logic [CW-1:0]             lo_ff, lo_in;
   logic [CW-1:0]             hi_ff, hi_in;
   logic [CW-1:0]             mid_ff, mid_in;
   logic [CW-1:0]             n_clamped;
   logic [ADDRESS_W-1:0]      key_ff;
   logic [ADDRESS_W-1:0]      rd_data_ff;
   logic                      found_ff;
   logic [REGION_INDEX_W-1:0] region_ff;
   logic                      slot_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write_enable) begin
         count_ff <= csr_entry_count;
      end
   end

   always_comb begin
      if (32'(count_ff) > 32'(MAX_ENTRIES)) begin
         n_clamped = CW'(MAX_ENTRIES);
      end else begin
         n_clamped = CW'(count_ff);
      end
   end

   assign slot_ok = 32'(req_entry_index) < 32'(MAX_ENTRIES);

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      priority if (cmd.query) begin
         lo_in = '0;
         hi_in = n_clamped;
      end else if (cmd.step) begin
         if (key_ff < rd_data_ff) begin
            hi_in = mid_ff;
         end else begin
            lo_in = mid_ff + 1'b1;
         end
      end
      mid_in = lo_in + ((hi_in - lo_in) >> 1);
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      if (cmd.query) begin
         key_ff <= req_address;
      end
      if (cmd.finish) begin
         found_ff  <= (lo_ff != '0);
         region_ff <= (lo_ff != '0) ? REGION_INDEX_W'(CW'(lo_ff - 1'b1)) : '0;
      end
   end

   // table port: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.load && slot_ok) begin
         mem[AW'(req_entry_index)] <= req_address;
      end
      rd_data_ff <= mem[AW'(mid_in)];
   end

   assign status.lo_lt_hi  = (lo_ff < hi_ff);
   assign rsp_found        = found_ff;
   assign rsp_region_index = region_ff;

endmodule
`default_nettype wire

@@ rtl/sil_checker.sv @@
`default_nettype none
`include "sorted_interval_lookup_defines.svh"
module sil_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 start,
   input wire logic                                 busy,
   input wire logic [sil_pkg::KIND_W-1:0]           req_kind,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_found,
   input wire logic [sil_pkg::REGION_INDEX_W-1:0]   rsp_region_index
);
   import sil_pkg::*;

   `SIL_ASSERT_NEXT(a_query_goes_busy, clock, reset, start && !busy && req_kind == KIND_QUERY, busy)
   `SIL_ASSERT_NEXT(a_load_stays_free, clock, reset, start && !busy && req_kind == KIND_LOAD, !busy)
   `SIL_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   `SIL_ASSERT_NOW(a_result_frees, clock, reset, rsp_valid, !busy)
   `SIL_ASSERT_NOW(a_miss_index_zero, clock, reset, rsp_valid && !rsp_found, rsp_region_index == '0)

endmodule

bind sorted_interval_lookup sil_checker u_sil_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_kind         (req_kind),
   .rsp_valid        (rsp_valid),
   .rsp_found        (rsp_found),
   .rsp_region_index (rsp_region_index)
);
`default_nettype wire
